// ===== src/hsv_to_rgb_convert_top_macros.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERT_TOP_MACROS_SVH
`define HSV_TO_RGB_CONVERT_TOP_MACROS_SVH

// Same-cycle implication
`define HSV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HSV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants, sector codes and the classified item type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // Valid input ranges
    localparam logic [8:0] HUE_MAX    = 9'd360;
    localparam logic [6:0] PCT_MAX    = 7'd100;
    localparam logic [5:0] SECTOR_DEG = 6'd60;

    // Channel scaling: floor(255*sum/600000) = floor(floor(17*sum/64)/625)
    localparam logic [4:0]  CHAN_MUL    = 5'd17;
    localparam int          PRE_SHIFT   = 6;
    // ceil(2^28/625), exact for dividends below 2^18
    localparam logic [18:0] RECIP_K     = 19'd429497;
    localparam int          RECIP_SHIFT = 28;

    // Default depth of the front/back queue
    localparam int QUEUE_DEPTH = 4;

    // Hue sectors of 60 degrees
    localparam logic [2:0] SEC_RY = 3'd0;  // red = C, green = X
    localparam logic [2:0] SEC_YG = 3'd1;  // red = X, green = C
    localparam logic [2:0] SEC_GC = 3'd2;  // green = C, blue = X
    localparam logic [2:0] SEC_CB = 3'd3;  // green = X, blue = C
    localparam logic [2:0] SEC_BM = 3'd4;  // red = X, blue = C
    localparam logic [2:0] SEC_MR = 3'd5;  // red = C, blue = X

    // Item handed from front to back
    typedef struct packed {
        logic       range_err;
        logic [2:0] sector;
        logic [5:0] hue_off;   // |(hue mod 120) - 60|
        logic [6:0] sat;
        logic [6:0] bri;
    } t_item;

    // Queue status toward the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== src/hsv_to_rgb_convert_top.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter top level
// Hue in degrees, saturation and value in percent in; 8-bit RGB and the
// packed 24-bit color out, with a range error flag.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                     Content
//  s_axis    in   tvalid/tready/tdata[23:0]   hue, saturation, brightness
//  m_axis    out  tvalid/tready/tdata[47:0]   red, green, blue, packed_color
//                 tuser[0]                    range_error
//
//  One item per clock sustained while the output is ready; an input transfer
//  passes through the front register, the queue and four back stages.
//  The front register and a four-entry queue let the input keep flowing while
//  the output is stalled, until the queue fills.
//  Reset clears the valid flags and the queue pointers; payload is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_convert_top #(
    parameter int QUEUE_DEPTH = hsv2rgb_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // hue[8:0], saturation[15:9], brightness[22:16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // red[7:0], green[15:8], blue[23:16], packed_color[47:24]
    output logic [0:0]  o_m_axis_tuser    // range_error[0]
);

    hsv2rgb_pkg::t_item   w_push_item;
    hsv2rgb_pkg::t_item   w_head_item;
    hsv2rgb_pkg::t_q_stat w_q_stat;
    logic                 w_push;
    logic                 w_pop;
    logic [7:0]           w_red, w_green, w_blue;
    logic [23:0]          w_packed;
    logic                 w_err;

    // Accept and classify
    hsv2rgb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_hue    (i_s_axis_tdata[8:0]),
        .i_sat    (i_s_axis_tdata[15:9]),
        .i_bri    (i_s_axis_tdata[22:16]),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    // Decouple front and back
    hsv2rgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_stat  (w_q_stat)
    );

    // Arithmetic pipeline
    hsv2rgb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_q_stat.empty),
        .i_item   (w_head_item),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_red    (w_red),
        .o_green  (w_green),
        .o_blue   (w_blue),
        .o_packed (w_packed),
        .o_err    (w_err)
    );

    assign o_m_axis_tdata = {w_packed, w_blue, w_green, w_red};
    assign o_m_axis_tuser = w_err;

endmodule

// ===== src/hsv2rgb_front.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Accepts input transfers, checks ranges and works out the hue sector and the
// distance term, then pushes the classified item into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv2rgb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [8:0]            i_hue,
    input  logic [6:0]            i_sat,
    input  logic [6:0]            i_bri,
    input  hsv2rgb_pkg::t_q_stat  i_q_stat,
    output logic                  o_push,
    output hsv2rgb_pkg::t_item    o_item
);

    logic               r_vld;
    hsv2rgb_pkg::t_item r_item;
    hsv2rgb_pkg::t_item n_item;
    logic [8:0]         w_hm;
    logic               w_take;

    // Hold the item until the queue has room
    assign o_push  = r_vld && !i_q_stat.full;
    assign o_ready = !r_vld || !i_q_stat.full;
    assign w_take  = i_valid && o_ready;
    assign o_item  = r_item;

    // Classify the incoming transfer
    always_comb begin
        n_item.range_err = (i_hue > hsv2rgb_pkg::HUE_MAX) || (i_sat > hsv2rgb_pkg::PCT_MAX)
                         || (i_bri > hsv2rgb_pkg::PCT_MAX);
        n_item.sat = i_sat;
        n_item.bri = i_bri;

        if (i_hue >= 9'd300) begin
            n_item.sector = hsv2rgb_pkg::SEC_MR;
        end else if (i_hue >= 9'd240) begin
            n_item.sector = hsv2rgb_pkg::SEC_BM;
        end else if (i_hue >= 9'd180) begin
            n_item.sector = hsv2rgb_pkg::SEC_CB;
        end else if (i_hue >= 9'd120) begin
            n_item.sector = hsv2rgb_pkg::SEC_GC;
        end else if (i_hue >= 9'd60) begin
            n_item.sector = hsv2rgb_pkg::SEC_YG;
        end else begin
            n_item.sector = hsv2rgb_pkg::SEC_RY;
        end

        // Hue mod 120 over the valid range
        if (i_hue >= 9'd360) begin
            w_hm = i_hue - 9'd360;
        end else if (i_hue >= 9'd240) begin
            w_hm = i_hue - 9'd240;
        end else if (i_hue >= 9'd120) begin
            w_hm = i_hue - 9'd120;
        end else begin
            w_hm = i_hue;
        end

        if (w_hm >= {3'd0, hsv2rgb_pkg::SECTOR_DEG}) begin
            n_item.hue_off = 6'(w_hm - {3'd0, hsv2rgb_pkg::SECTOR_DEG});
        end else begin
            n_item.hue_off = 6'({3'd0, hsv2rgb_pkg::SECTOR_DEG} - w_hm);
        end
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    // Item register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== src/hsv2rgb_queue.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB item queue
// Short circular buffer between front and back so each side stalls alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hsv_to_rgb_convert_top_macros.svh"

module hsv2rgb_queue #(
    parameter int DEPTH = hsv2rgb_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  hsv2rgb_pkg::t_item    i_item,
    input  logic                  i_pop,
    output hsv2rgb_pkg::t_item    o_item,
    output hsv2rgb_pkg::t_q_stat  o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsv2rgb_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]      r_wr_ptr;
    logic [PW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_cnt;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_item       = r_mem[r_rd_ptr];

    // Write the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `HSV_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= CW'(DEPTH), "queue count beyond depth")
    `HSV_ASSERT_IMP(a_no_overflow, o_stat.full, !i_push, "push into full queue")
    `HSV_ASSERT_IMP(a_no_underflow, o_stat.empty, !i_pop, "pop from empty queue")

endmodule

// ===== src/hsv2rgb_back.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB back end
// Four-stage arithmetic pipeline: products, channel sums, scaling by 17/64,
// reciprocal division by 625 into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hsv_to_rgb_convert_top_macros.svh"

module hsv2rgb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hsv2rgb_pkg::t_item  i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [23:0]         o_packed,
    output logic                o_err
);

    logic        w_en;
    logic        r_v1, r_v2, r_v3, r_v4;

    // Stage 1: S*V, V*(100-S), 60-hue_off
    logic [13:0] r1_sv, r1_vm;
    logic [5:0]  r1_wx;
    logic [2:0]  r1_sec;
    logic        r1_err;

    // Stage 2: channel sums part + M
    logic [19:0] w2_c, w2_x, w2_m;
    logic [19:0] n2_r, n2_g, n2_b;
    logic [19:0] r2_r, r2_g, r2_b;
    logic        r2_err;

    // Stage 3: floor(17*sum/64)
    logic [24:0] w3_r, w3_g, w3_b;
    logic [18:0] r3_r, r3_g, r3_b;
    logic        r3_err;

    // Stage 4: divide by 625
    logic [37:0] w4_r, w4_g, w4_b;
    logic [7:0]  r4_r, r4_g, r4_b;
    logic        r4_err;

    // Move the whole pipeline while the output register is free or taken
    assign w_en  = !r_v4 || i_ready;
    assign o_pop = i_valid && w_en;

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage 2 products and sector routing
    always_comb begin
        w2_c = 20'(r1_sv) * 20'(hsv2rgb_pkg::SECTOR_DEG);
        w2_x = 20'(r1_sv) * 20'(r1_wx);
        w2_m = 20'(r1_vm) * 20'(hsv2rgb_pkg::SECTOR_DEG);
        case (r1_sec)
            hsv2rgb_pkg::SEC_RY: begin
                n2_r = w2_c + w2_m; n2_g = w2_x + w2_m; n2_b = w2_m;
            end
            hsv2rgb_pkg::SEC_YG: begin
                n2_r = w2_x + w2_m; n2_g = w2_c + w2_m; n2_b = w2_m;
            end
            hsv2rgb_pkg::SEC_GC: begin
                n2_r = w2_m; n2_g = w2_c + w2_m; n2_b = w2_x + w2_m;
            end
            hsv2rgb_pkg::SEC_CB: begin
                n2_r = w2_m; n2_g = w2_x + w2_m; n2_b = w2_c + w2_m;
            end
            hsv2rgb_pkg::SEC_BM: begin
                n2_r = w2_x + w2_m; n2_g = w2_m; n2_b = w2_c + w2_m;
            end
            default: begin
                n2_r = w2_c + w2_m; n2_g = w2_m; n2_b = w2_x + w2_m;
            end
        endcase
    end

    // Scale terms for stages 3 and 4
    assign w3_r = 25'(r2_r) * 25'(hsv2rgb_pkg::CHAN_MUL);
    assign w3_g = 25'(r2_g) * 25'(hsv2rgb_pkg::CHAN_MUL);
    assign w3_b = 25'(r2_b) * 25'(hsv2rgb_pkg::CHAN_MUL);
    assign w4_r = 38'(r3_r) * 38'(hsv2rgb_pkg::RECIP_K);
    assign w4_g = 38'(r3_g) * 38'(hsv2rgb_pkg::RECIP_K);
    assign w4_b = 38'(r3_b) * 38'(hsv2rgb_pkg::RECIP_K);

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sv  <= 14'(i_item.sat) * 14'(i_item.bri);
            r1_vm  <= 14'(i_item.bri) * 14'(hsv2rgb_pkg::PCT_MAX - i_item.sat);
            r1_wx  <= hsv2rgb_pkg::SECTOR_DEG - i_item.hue_off;
            r1_sec <= i_item.sector;
            r1_err <= i_item.range_err;

            r2_r   <= n2_r;
            r2_g   <= n2_g;
            r2_b   <= n2_b;
            r2_err <= r1_err;

            r3_r   <= w3_r[hsv2rgb_pkg::PRE_SHIFT +: 19];
            r3_g   <= w3_g[hsv2rgb_pkg::PRE_SHIFT +: 19];
            r3_b   <= w3_b[hsv2rgb_pkg::PRE_SHIFT +: 19];
            r3_err <= r2_err;

            // Drop the channels to zero on a range error
            r4_r   <= r3_err ? 8'd0 : w4_r[hsv2rgb_pkg::RECIP_SHIFT +: 8];
            r4_g   <= r3_err ? 8'd0 : w4_g[hsv2rgb_pkg::RECIP_SHIFT +: 8];
            r4_b   <= r3_err ? 8'd0 : w4_b[hsv2rgb_pkg::RECIP_SHIFT +: 8];
            r4_err <= r3_err;
        end
    end

    assign o_valid  = r_v4;
    assign o_red    = r4_r;
    assign o_green  = r4_g;
    assign o_blue   = r4_b;
    assign o_packed = {r4_r, r4_g, r4_b};
    assign o_err    = r4_err;

    `HSV_ASSERT_IMP(a_err_zero, o_valid && o_err, o_packed == 24'd0, "error result not zero")
    `HSV_ASSERT_NXT(a_pop_fills, o_pop, r_v1, "popped item lost in stage 1")
    `HSV_ASSERT_IMP(a_stall_keeps, !w_en, r_v4, "pipeline stalled without a result")

endmodule

// ===== tb/tb_hsv_to_rgb_convert_top.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Streams hue/saturation/value pixels into the converter and checks every
// output transfer against an in-order queue of predicted colors. A directed
// set of corners comes first, then random pixels with bursty input, a
// stalling output, a long output hold-off and a full-rate stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hsv_to_rgb_convert_top;

    // Cycles without any transfer before the run is abandoned
    localparam int STALL_LIMIT = 1000;
    // Length of the long output hold-off
    localparam int HOLD_CYCLES = 80;
    // Cycles allowed after the last result for stray transfers
    localparam int DRAIN_CYCLES = 20;

    // Output side behavior
    typedef enum logic {
        SINK_ALWAYS,
        SINK_RANDOM
    } t_sink_mode;

    // One predicted output transfer
    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] packed_color;
        logic        range_error;
    } t_rgb_color;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;   // hue[8:0], saturation[15:9], brightness[22:16]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;        // red[7:0], green[15:8], blue[23:16], packed_color[47:24]
    logic [0:0]  o_m_axis_tuser;        // range_error[0]

    t_rgb_color  color_queue[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;

    // Sender burst control
    bit          gaps_on = 1'b1;
    int          burst_left = 0;

    // Receiver control
    t_sink_mode  sink_mode = SINK_ALWAYS;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          run_left = 0;
    bit          run_ready = 1'b1;

    hsv_to_rgb_convert_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Generate the 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Scale one channel sum (over 600000) down to 8 bits
    function automatic logic [7:0] to_level(input int unsigned sum);
        int unsigned level;
        level = (255 * sum) / 600000;
        return (level > 255) ? 8'd255 : level[7:0];
    endfunction

    // Predict the converter output for one pixel
    function automatic t_rgb_color predict_color(input logic [8:0] hue,
                                                 input logic [6:0] sat,
                                                 input logic [6:0] bri);
        t_rgb_color  col;
        int unsigned chroma, second, offset, hue_mod, hue_off;
        int unsigned r_part, g_part, b_part;
        logic [2:0]  sector;
        col = '{default: '0};
        if (hue > hsv2rgb_pkg::HUE_MAX || sat > hsv2rgb_pkg::PCT_MAX
                || bri > hsv2rgb_pkg::PCT_MAX) begin
            col.range_error = 1'b1;
            return col;
        end
        chroma  = sat * bri * 60;
        hue_mod = hue % 120;
        hue_off = (hue_mod >= 60) ? hue_mod - 60 : 60 - hue_mod;
        second  = sat * bri * (60 - hue_off);
        offset  = bri * (100 - sat) * 60;
        // Hue 360 belongs to the last sector
        sector  = (hue / 60 > 5) ? hsv2rgb_pkg::SEC_MR : 3'(hue / 60);
        case (sector)
            hsv2rgb_pkg::SEC_RY: begin
                r_part = chroma; g_part = second; b_part = 0;
            end
            hsv2rgb_pkg::SEC_YG: begin
                r_part = second; g_part = chroma; b_part = 0;
            end
            hsv2rgb_pkg::SEC_GC: begin
                r_part = 0;      g_part = chroma; b_part = second;
            end
            hsv2rgb_pkg::SEC_CB: begin
                r_part = 0;      g_part = second; b_part = chroma;
            end
            hsv2rgb_pkg::SEC_BM: begin
                r_part = second; g_part = 0;      b_part = chroma;
            end
            default: begin
                r_part = chroma; g_part = 0;      b_part = second;
            end
        endcase
        col.red          = to_level(r_part + offset);
        col.green        = to_level(g_part + offset);
        col.blue         = to_level(b_part + offset);
        col.packed_color = {col.red, col.green, col.blue};
        return col;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string field, input logic [23:0] want,
                                   input logic [23:0] got);
        $display("ERROR at %0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Offer one pixel, hold it until transferred, then maybe open a gap
    task automatic send_pixel(input logic [8:0] hue, input logic [6:0] sat,
                              input logic [6:0] bri);
        int gap;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, bri, sat, hue};
        do @(posedge i_clk); while (!o_s_axis_tready);
        color_queue.insert(color_queue.size(), predict_color(hue, sat, bri));
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 5);
                repeat (gap) begin
                    @(negedge i_clk);
                    i_s_axis_tvalid <= 1'b0;
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    // Drive the output ready: long hold-off on request, else the sink pattern
    always @(negedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (sink_mode == SINK_ALWAYS) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            // Ready and stall in runs of random length
            if (run_left == 0) begin
                run_left  = $urandom_range(1, 8);
                run_ready = ($urandom_range(0, 9) < 7);
            end
            run_left--;
            i_m_axis_tready <= run_ready;
        end
    end

    // Check each output transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_rgb_color want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (color_queue.size() == 0) begin
                report_mismatch("unexpected result", 24'd0, o_m_axis_tdata[47:24]);
            end else begin
                want = color_queue.pop_front();
                if (o_m_axis_tdata[7:0] !== want.red)
                    report_mismatch("red", want.red, o_m_axis_tdata[7:0]);
                if (o_m_axis_tdata[15:8] !== want.green)
                    report_mismatch("green", want.green, o_m_axis_tdata[15:8]);
                if (o_m_axis_tdata[23:16] !== want.blue)
                    report_mismatch("blue", want.blue, o_m_axis_tdata[23:16]);
                if (o_m_axis_tdata[47:24] !== want.packed_color)
                    report_mismatch("packed_color", want.packed_color,
                                    o_m_axis_tdata[47:24]);
                if (o_m_axis_tuser[0] !== want.range_error)
                    report_mismatch("range_error", want.range_error, o_m_axis_tuser[0]);
            end
        end
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR at %0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("** hsv_to_rgb_convert_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sector boundaries, sector centers, hue 360 and out-of-range inputs
    task automatic test_directed_corners();
        sink_mode = SINK_ALWAYS;
        gaps_on   = 1'b0;
        send_pixel(9'd0,   7'd0,   7'd0);
        send_pixel(9'd0,   7'd100, 7'd100);
        send_pixel(9'd60,  7'd100, 7'd100);
        send_pixel(9'd120, 7'd100, 7'd100);
        send_pixel(9'd180, 7'd100, 7'd100);
        send_pixel(9'd240, 7'd100, 7'd100);
        send_pixel(9'd300, 7'd100, 7'd100);
        send_pixel(9'd360, 7'd100, 7'd100);
        send_pixel(9'd30,  7'd100, 7'd100);
        send_pixel(9'd90,  7'd100, 7'd100);
        send_pixel(9'd150, 7'd100, 7'd100);
        send_pixel(9'd210, 7'd100, 7'd100);
        send_pixel(9'd270, 7'd100, 7'd100);
        send_pixel(9'd330, 7'd100, 7'd100);
        send_pixel(9'd359, 7'd73,  7'd41);
        send_pixel(9'd1,   7'd100, 7'd1);
        send_pixel(9'd360, 7'd0,   7'd100);
        send_pixel(9'd200, 7'd0,   7'd100);
        send_pixel(9'd45,  7'd50,  7'd100);
        // Out of range on each field and on all of them
        send_pixel(9'd361, 7'd50,  7'd50);
        send_pixel(9'd511, 7'd127, 7'd127);
        send_pixel(9'd0,   7'd101, 7'd0);
        send_pixel(9'd0,   7'd0,   7'd101);
        send_pixel(9'd100, 7'd127, 7'd50);
        send_pixel(9'd360, 7'd100, 7'd101);
    endtask

    // In-range pixels with bursty input and a stalling output
    task automatic test_random_valid(input int count);
        sink_mode = SINK_RANDOM;
        gaps_on   = 1'b1;
        repeat (count) begin
            send_pixel(9'($urandom_range(0, 360)), 7'($urandom_range(0, 100)),
                       7'($urandom_range(0, 100)));
        end
    endtask

    // Any bit pattern on every field, mostly out of range
    task automatic test_random_raw(input int count);
        sink_mode = SINK_RANDOM;
        gaps_on   = 1'b1;
        repeat (count) begin
            send_pixel(9'($urandom_range(0, 511)), 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)));
        end
    endtask

    // Hold the output off while pixels keep coming, so the input stalls
    task automatic test_output_hold(input int count);
        sink_mode = SINK_ALWAYS;
        gaps_on   = 1'b0;
        hold_reqs++;
        repeat (count) begin
            send_pixel(9'($urandom_range(0, 360)), 7'($urandom_range(0, 100)),
                       7'($urandom_range(0, 100)));
        end
    endtask

    // Back-to-back pixels with the output always ready
    task automatic test_full_rate(input int count);
        sink_mode = SINK_ALWAYS;
        gaps_on   = 1'b0;
        repeat (count) begin
            send_pixel(9'($urandom_range(0, 360)), 7'($urandom_range(0, 100)),
                       7'($urandom_range(0, 100)));
        end
    endtask

    // Reset once, run the tests in turn, drain and report
    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_random_valid(360);
        test_output_hold(40);
        test_random_raw(100);
        test_full_rate(50);
        test_random_valid(30);

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (color_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("** hsv_to_rgb_convert_top: PASSED **");
        end else begin
            $display("** hsv_to_rgb_convert_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/hsv2rgb_pkg.sv
src/hsv2rgb_front.sv
src/hsv2rgb_queue.sv
src/hsv2rgb_back.sv
src/hsv_to_rgb_convert_top.sv
tb/tb_hsv_to_rgb_convert_top.sv
